// ----- hdl/rvd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared codes, tables and stage item types for the RV32I decoder pipeline.
// ----------------------------------------------------------------------------
package rvd_pkg;

   localparam int MNEM_W = 6;
   localparam int FORM_W = 4;
   localparam int REG_W  = 5;
   localparam int XLEN   = 32;

   // mnemonic codes
   localparam logic [MNEM_W-1:0] MN_LB         = 6'd0;
   localparam logic [MNEM_W-1:0] MN_LH         = 6'd1;
   localparam logic [MNEM_W-1:0] MN_LW         = 6'd2;
   localparam logic [MNEM_W-1:0] MN_LBU        = 6'd3;
   localparam logic [MNEM_W-1:0] MN_LHU        = 6'd4;
   localparam logic [MNEM_W-1:0] MN_LOAD_BAD   = 6'd5;
   localparam logic [MNEM_W-1:0] MN_NOP        = 6'd6;
   localparam logic [MNEM_W-1:0] MN_ADDI       = 6'd7;
   localparam logic [MNEM_W-1:0] MN_SLLI       = 6'd8;
   localparam logic [MNEM_W-1:0] MN_SLTI       = 6'd9;
   localparam logic [MNEM_W-1:0] MN_SLTIU      = 6'd10;
   localparam logic [MNEM_W-1:0] MN_XORI       = 6'd11;
   localparam logic [MNEM_W-1:0] MN_SRLI       = 6'd12;
   localparam logic [MNEM_W-1:0] MN_SRAI       = 6'd13;
   localparam logic [MNEM_W-1:0] MN_ORI        = 6'd14;
   localparam logic [MNEM_W-1:0] MN_ANDI       = 6'd15;
   localparam logic [MNEM_W-1:0] MN_AUIPC      = 6'd16;
   localparam logic [MNEM_W-1:0] MN_SB         = 6'd17;
   localparam logic [MNEM_W-1:0] MN_SH         = 6'd18;
   localparam logic [MNEM_W-1:0] MN_SW         = 6'd19;
   localparam logic [MNEM_W-1:0] MN_STORE_BAD  = 6'd20;
   localparam logic [MNEM_W-1:0] MN_ADD        = 6'd21;
   localparam logic [MNEM_W-1:0] MN_SUB        = 6'd22;
   localparam logic [MNEM_W-1:0] MN_SLL        = 6'd23;
   localparam logic [MNEM_W-1:0] MN_SLT        = 6'd24;
   localparam logic [MNEM_W-1:0] MN_SLTU       = 6'd25;
   localparam logic [MNEM_W-1:0] MN_XOR        = 6'd26;
   localparam logic [MNEM_W-1:0] MN_SRL        = 6'd27;
   localparam logic [MNEM_W-1:0] MN_SRA        = 6'd28;
   localparam logic [MNEM_W-1:0] MN_OR         = 6'd29;
   localparam logic [MNEM_W-1:0] MN_AND        = 6'd30;
   localparam logic [MNEM_W-1:0] MN_LUI        = 6'd31;
   localparam logic [MNEM_W-1:0] MN_BEQ        = 6'd32;
   localparam logic [MNEM_W-1:0] MN_BNE        = 6'd33;
   localparam logic [MNEM_W-1:0] MN_BLT        = 6'd34;
   localparam logic [MNEM_W-1:0] MN_BGE        = 6'd35;
   localparam logic [MNEM_W-1:0] MN_BLTU       = 6'd36;
   localparam logic [MNEM_W-1:0] MN_BGEU       = 6'd37;
   localparam logic [MNEM_W-1:0] MN_BRANCH_BAD = 6'd38;
   localparam logic [MNEM_W-1:0] MN_RET        = 6'd39;
   localparam logic [MNEM_W-1:0] MN_JR         = 6'd40;
   localparam logic [MNEM_W-1:0] MN_JALR       = 6'd41;
   localparam logic [MNEM_W-1:0] MN_J          = 6'd42;
   localparam logic [MNEM_W-1:0] MN_CALL       = 6'd43;
   localparam logic [MNEM_W-1:0] MN_JAL        = 6'd44;
   localparam logic [MNEM_W-1:0] MN_ECALL      = 6'd45;
   localparam logic [MNEM_W-1:0] MN_EBREAK     = 6'd46;
   localparam logic [MNEM_W-1:0] MN_SYSTEM     = 6'd47;
   localparam logic [MNEM_W-1:0] MN_FENCE      = 6'd48;
   localparam logic [MNEM_W-1:0] MN_UNKNOWN    = 6'd49;

   // operand layout codes
   localparam logic [FORM_W-1:0] FORM_NONE       = 4'd0;
   localparam logic [FORM_W-1:0] FORM_RD_RS1_IMM = 4'd1;
   localparam logic [FORM_W-1:0] FORM_RD_MEM     = 4'd2;
   localparam logic [FORM_W-1:0] FORM_RS2_MEM    = 4'd3;
   localparam logic [FORM_W-1:0] FORM_RD_RS1_RS2 = 4'd4;
   localparam logic [FORM_W-1:0] FORM_RD_UPPER   = 4'd5;
   localparam logic [FORM_W-1:0] FORM_BRANCH     = 4'd6;
   localparam logic [FORM_W-1:0] FORM_RS1        = 4'd7;
   localparam logic [FORM_W-1:0] FORM_TARGET     = 4'd8;
   localparam logic [FORM_W-1:0] FORM_RD_TARGET  = 4'd9;

   // major opcodes
   localparam logic [6:0] OPC_LOAD     = 7'h03;
   localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
   localparam logic [6:0] OPC_OP_IMM   = 7'h13;
   localparam logic [6:0] OPC_AUIPC    = 7'h17;
   localparam logic [6:0] OPC_STORE    = 7'h23;
   localparam logic [6:0] OPC_OP       = 7'h33;
   localparam logic [6:0] OPC_LUI      = 7'h37;
   localparam logic [6:0] OPC_BRANCH   = 7'h63;
   localparam logic [6:0] OPC_JALR     = 7'h67;
   localparam logic [6:0] OPC_JAL      = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM   = 7'h73;

   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SR      = 3'd5;
   localparam logic [2:0] F3_ST_MAX  = 3'd2;

   localparam logic [REG_W-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_W-1:0] REG_RA   = 5'd1;

   localparam logic [XLEN-1:0] WORD_NOP    = 32'h0000_0013;
   localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;

   // funct3 lookup tables
   localparam logic [MNEM_W-1:0] LOAD_MNEM [8] = '{
      MN_LB, MN_LH, MN_LW, MN_LOAD_BAD, MN_LBU, MN_LHU, MN_LOAD_BAD, MN_LOAD_BAD};
   localparam logic [MNEM_W-1:0] OPIMM_MNEM [8] = '{
      MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_ORI, MN_ANDI};
   localparam logic [MNEM_W-1:0] OP_MNEM [8] = '{
      MN_ADD, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_OR, MN_AND};
   localparam logic [MNEM_W-1:0] BRANCH_MNEM [8] = '{
      MN_BEQ, MN_BNE, MN_BRANCH_BAD, MN_BRANCH_BAD, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
   localparam logic [MNEM_W-1:0] STORE_MNEM [4] = '{
      MN_SB, MN_SH, MN_SW, MN_STORE_BAD};

   // decode stage to target stage
   typedef struct packed {
      logic [MNEM_W-1:0] mnemonic;
      logic [FORM_W-1:0] form;
      logic [REG_W-1:0]  rd;
      logic [REG_W-1:0]  rs1;
      logic [REG_W-1:0]  rs2;
      logic [XLEN-1:0]   imm;
      logic              has_target;
      logic [XLEN-1:0]   offset;
      logic [XLEN-1:0]   addr;
   } decoded_type;

   // target stage to output stage
   typedef struct packed {
      logic [MNEM_W-1:0] mnemonic;
      logic [FORM_W-1:0] form;
      logic [REG_W-1:0]  rd;
      logic [REG_W-1:0]  rs1;
      logic [REG_W-1:0]  rs2;
      logic [XLEN-1:0]   imm;
      logic [XLEN-1:0]   target;
   } resolved_type;

endpackage

// ----- hdl/rvd_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_channels
// Valid/ready channels for instruction items and decoded result items.
// ----------------------------------------------------------------------------
interface rvd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   logic [31:0] instr_addr;

   modport source (output valid, output instr_word, output instr_addr, input ready);
   modport sink (input valid, input instr_word, input instr_addr, output ready);
endinterface

interface rvd_rsp_if;
   logic               valid;
   logic               ready;
   logic        [5:0]  mnemonic;
   logic        [3:0]  operand_form;
   logic        [4:0]  dest_reg;
   logic        [4:0]  src1_reg;
   logic        [4:0]  src2_reg;
   logic signed [31:0] shown_immediate;
   logic        [31:0] jump_target;

   modport source (
      output valid, output mnemonic, output operand_form, output dest_reg,
      output src1_reg, output src2_reg, output shown_immediate, output jump_target,
      input ready);
   modport sink (
      input valid, input mnemonic, input operand_form, input dest_reg,
      input src1_reg, input src2_reg, input shown_immediate, input jump_target,
      output ready);
endinterface

// ----- hdl/rv32i_instruction_decoder.sv -----
`timescale 1ns / 1ps
// path: each accepted item passes the decode, target add and output registers in that order
// before its result is shown on the response channel
// throughput: one item per cycle while rsp_if.ready holds; each stage register moves on when
// it is empty or the next stage takes its item, so a full pipe streams without bubbles
// reset: synchronous, active high; clears the three stage valid bits only
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Three-stage pipelined RV32I decoder: mnemonic and operand form, register
// numbers, shown immediate and branch or jump target per instruction item.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder (
   input  logic      clock,
   input  logic      reset,
   rvd_req_if.sink   req_if,
   rvd_rsp_if.source rsp_if
);

   logic                  dec_valid;
   logic                  dec_ready;
   rvd_pkg::decoded_type  dec_data;
   logic                  tgt_valid;
   logic                  tgt_ready;
   rvd_pkg::resolved_type tgt_data;

   rvd_decode_stage u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_word   (req_if.instr_word),
      .in_addr   (req_if.instr_addr),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   rvd_target_stage u_target (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (tgt_valid),
      .out_ready (tgt_ready),
      .out_data  (tgt_data)
   );

   rvd_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .in_valid (tgt_valid),
      .in_ready (tgt_ready),
      .in_data  (tgt_data),
      .rsp_if   (rsp_if)
   );

endmodule

// ----- hdl/rvd_decode_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_decode_stage
// First stage: opcode/funct decode, immediate extraction, target offset.
// ----------------------------------------------------------------------------
module rvd_decode_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         in_word,
   input  logic [31:0]         in_addr,
   output logic                out_valid,
   input  logic                out_ready,
   output rvd_pkg::decoded_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   logic                 load;
   rvd_pkg::decoded_type data_ff;
   rvd_pkg::decoded_type data_in;

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;

   assign opc   = in_word[6:0];
   assign rd    = in_word[11:7];
   assign f3    = in_word[14:12];
   assign rs1   = in_word[19:15];
   assign rs2   = in_word[24:20];
   assign f7    = in_word[31:25];
   assign imm_i = {{20{in_word[31]}}, in_word[31:20]};
   assign imm_s = {{20{in_word[31]}}, in_word[31:25], in_word[11:7]};
   assign imm_b = {{19{in_word[31]}}, in_word[31], in_word[7], in_word[30:25],
                   in_word[11:8], 1'b0};
   assign imm_j = {{11{in_word[31]}}, in_word[31], in_word[19:12], in_word[20],
                   in_word[30:21], 1'b0};
   assign imm_u = {12'd0, in_word[31:12]};

   always_comb begin
      data_in            = '0;
      data_in.rd         = rd;
      data_in.rs1        = rs1;
      data_in.rs2        = rs2;
      data_in.addr       = in_addr;
      data_in.mnemonic   = rvd_pkg::MN_UNKNOWN;
      data_in.form       = rvd_pkg::FORM_NONE;
      unique case (opc)
         rvd_pkg::OPC_LOAD: begin
            data_in.mnemonic = rvd_pkg::LOAD_MNEM[f3];
            data_in.form     = rvd_pkg::FORM_RD_MEM;
            data_in.imm      = imm_i;
         end
         rvd_pkg::OPC_OP_IMM: begin
            if (in_word == rvd_pkg::WORD_NOP) begin
               data_in.mnemonic = rvd_pkg::MN_NOP;
            end else begin
               data_in.form = rvd_pkg::FORM_RD_RS1_IMM;
               if (f3 == rvd_pkg::F3_SR && f7 != 7'd0) begin
                  data_in.mnemonic = rvd_pkg::MN_SRAI;
               end else begin
                  data_in.mnemonic = rvd_pkg::OPIMM_MNEM[f3];
               end
               if (f3 == rvd_pkg::F3_SLL || f3 == rvd_pkg::F3_SR) begin
                  data_in.imm = {27'd0, rs2};
               end else begin
                  data_in.imm = imm_i;
               end
            end
         end
         rvd_pkg::OPC_AUIPC: begin
            data_in.mnemonic = rvd_pkg::MN_AUIPC;
            data_in.form     = rvd_pkg::FORM_RD_UPPER;
            data_in.imm      = imm_u;
         end
         rvd_pkg::OPC_STORE: begin
            if (f3 <= rvd_pkg::F3_ST_MAX) begin
               data_in.mnemonic = rvd_pkg::STORE_MNEM[f3[1:0]];
               data_in.form     = rvd_pkg::FORM_RS2_MEM;
               data_in.imm      = imm_s;
            end else begin
               data_in.mnemonic = rvd_pkg::MN_STORE_BAD;
            end
         end
         rvd_pkg::OPC_OP: begin
            data_in.form = rvd_pkg::FORM_RD_RS1_RS2;
            if (f7 != 7'd0 && f3 == rvd_pkg::F3_ADD_SUB) begin
               data_in.mnemonic = rvd_pkg::MN_SUB;
            end else if (f7 != 7'd0 && f3 == rvd_pkg::F3_SR) begin
               data_in.mnemonic = rvd_pkg::MN_SRA;
            end else begin
               data_in.mnemonic = rvd_pkg::OP_MNEM[f3];
            end
         end
         rvd_pkg::OPC_LUI: begin
            data_in.mnemonic = rvd_pkg::MN_LUI;
            data_in.form     = rvd_pkg::FORM_RD_UPPER;
            data_in.imm      = imm_u;
         end
         rvd_pkg::OPC_BRANCH: begin
            data_in.mnemonic   = rvd_pkg::BRANCH_MNEM[f3];
            data_in.form       = rvd_pkg::FORM_BRANCH;
            data_in.has_target = 1'b1;
            data_in.offset     = imm_b;
         end
         rvd_pkg::OPC_JALR: begin
            if (rd == rvd_pkg::REG_ZERO && rs1 == rvd_pkg::REG_RA && imm_i == 32'd0) begin
               data_in.mnemonic = rvd_pkg::MN_RET;
            end else if (rd == rvd_pkg::REG_ZERO && imm_i == 32'd0) begin
               data_in.mnemonic = rvd_pkg::MN_JR;
               data_in.form     = rvd_pkg::FORM_RS1;
            end else begin
               data_in.mnemonic = rvd_pkg::MN_JALR;
               data_in.form     = rvd_pkg::FORM_RD_MEM;
               data_in.imm      = imm_i;
            end
         end
         rvd_pkg::OPC_JAL: begin
            data_in.has_target = 1'b1;
            data_in.offset     = imm_j;
            if (rd == rvd_pkg::REG_ZERO) begin
               data_in.mnemonic = rvd_pkg::MN_J;
               data_in.form     = rvd_pkg::FORM_TARGET;
            end else if (rd == rvd_pkg::REG_RA) begin
               data_in.mnemonic = rvd_pkg::MN_CALL;
               data_in.form     = rvd_pkg::FORM_TARGET;
            end else begin
               data_in.mnemonic = rvd_pkg::MN_JAL;
               data_in.form     = rvd_pkg::FORM_RD_TARGET;
            end
         end
         rvd_pkg::OPC_SYSTEM: begin
            if (in_word == rvd_pkg::WORD_ECALL) begin
               data_in.mnemonic = rvd_pkg::MN_ECALL;
            end else if (in_word == rvd_pkg::WORD_EBREAK) begin
               data_in.mnemonic = rvd_pkg::MN_EBREAK;
            end else begin
               data_in.mnemonic = rvd_pkg::MN_SYSTEM;
            end
         end
         rvd_pkg::OPC_MISC_MEM: begin
            data_in.mnemonic = rvd_pkg::MN_FENCE;
         end
         default: begin
            data_in.mnemonic = rvd_pkg::MN_UNKNOWN;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/rvd_target_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_target_stage
// Second stage: branch and jump target add, address plus offset mod 2^32.
// ----------------------------------------------------------------------------
module rvd_target_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rvd_pkg::decoded_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rvd_pkg::resolved_type out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   rvd_pkg::resolved_type data_ff;
   rvd_pkg::resolved_type data_in;

   always_comb begin
      data_in.mnemonic = in_data.mnemonic;
      data_in.form     = in_data.form;
      data_in.rd       = in_data.rd;
      data_in.rs1      = in_data.rs1;
      data_in.rs2      = in_data.rs2;
      data_in.imm      = in_data.imm;
      if (in_data.has_target) begin
         data_in.target = in_data.addr + in_data.offset;
      end else begin
         data_in.target = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- hdl/rvd_output_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_output_stage
// Third stage: masks register fields the operand form does not show and
// holds the result item for the response channel.
// ----------------------------------------------------------------------------
module rvd_output_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rvd_pkg::resolved_type in_data,
   rvd_rsp_if.source             rsp_if
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   rvd_pkg::resolved_type data_ff;
   rvd_pkg::resolved_type data_in;
   logic                  keep_rd;
   logic                  keep_rs1;
   logic                  keep_rs2;

   always_comb begin
      keep_rd  = 1'b0;
      keep_rs1 = 1'b0;
      keep_rs2 = 1'b0;
      unique case (in_data.form)
         rvd_pkg::FORM_RD_RS1_IMM,
         rvd_pkg::FORM_RD_MEM: begin
            keep_rd  = 1'b1;
            keep_rs1 = 1'b1;
         end
         rvd_pkg::FORM_RS2_MEM,
         rvd_pkg::FORM_BRANCH: begin
            keep_rs1 = 1'b1;
            keep_rs2 = 1'b1;
         end
         rvd_pkg::FORM_RD_RS1_RS2: begin
            keep_rd  = 1'b1;
            keep_rs1 = 1'b1;
            keep_rs2 = 1'b1;
         end
         rvd_pkg::FORM_RD_UPPER,
         rvd_pkg::FORM_RD_TARGET: begin
            keep_rd = 1'b1;
         end
         rvd_pkg::FORM_RS1: begin
            keep_rs1 = 1'b1;
         end
         default: begin
            keep_rd = 1'b0;
         end
      endcase
   end

   always_comb begin
      data_in     = in_data;
      data_in.rd  = keep_rd  ? in_data.rd  : '0;
      data_in.rs1 = keep_rs1 ? in_data.rs1 : '0;
      data_in.rs2 = keep_rs2 ? in_data.rs2 : '0;
   end

   assign in_ready = !valid_ff || rsp_if.ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.mnemonic        = data_ff.mnemonic;
   assign rsp_if.operand_form    = data_ff.form;
   assign rsp_if.dest_reg        = data_ff.rd;
   assign rsp_if.src1_reg        = data_ff.rs1;
   assign rsp_if.src2_reg        = data_ff.rs2;
   assign rsp_if.shown_immediate = $signed(data_ff.imm);
   assign rsp_if.jump_target     = data_ff.target;

endmodule
